FILE: rtl/cau_pkg.sv
// Shared types and constants of the complex arithmetic unit.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package cau_pkg;

  // Fixed widths of the stream fields
  localparam int unsigned DATA_W = 32;
  localparam int unsigned ACT_W  = 2;

  // Default number format, signed Q16.16
  localparam int unsigned WORD_BITS_DEF = 32;
  localparam int unsigned FRAC_BITS_DEF = 16;

  typedef enum logic [ACT_W-1:0] {
    ACT_ADD = 2'd0,
    ACT_SUB = 2'd1,
    ACT_MUL = 2'd2,
    ACT_DIV = 2'd3
  } cau_action_e;

  // Side information that travels with each item through the divider
  typedef struct packed {
    logic is_div;
    logic dz;
    logic re_neg;
    logic im_neg;
  } cau_tag_t;

endpackage

FILE: rtl/complex_arithmetic_unit_core.sv
// Top level of the complex arithmetic unit: front end, divider chain, back end.
// Depends on cau_pkg, cau_front, cau_div_stage and cau_back.
//
//  channel   dir  tdata                              tuser
//  s_axis    in   a_real,a_imag,b_real,b_imag        action
//  m_axis    out  res_real,res_imag                  overflow,divide_by_zero
//
// One transaction per cycle in, one per cycle out while the skid register is
// empty. Every item runs through the front end, the chain of one-bit
// restoring division steps and the output register.
// Reset clears only valid bits. A stalled output fills the output register,
// then the skid register; only a full skid register stops the pipeline.
`timescale 1ns / 1ps

module complex_arithmetic_unit_core import cau_pkg::*; #(
  parameter int unsigned WORD_BITS = WORD_BITS_DEF,
  parameter int unsigned FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [4*DATA_W-1:0] s_axis_tdata,  // a_real, a_imag, b_real, b_imag
  input  logic [ACT_W-1:0]    s_axis_tuser,  // action
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [2*DATA_W-1:0] m_axis_tdata,  // res_real, res_imag
  output logic [1:0]          m_axis_tuser   // overflow, divide_by_zero
);

  localparam int unsigned W  = WORD_BITS;
  localparam int unsigned PW = 2 * WORD_BITS;
  localparam int unsigned N  = PW + FRAC_BITS;

  logic en;

  // divider chain taps
  logic          d_v    [N+1];
  cau_tag_t      d_tag  [N+1];
  logic [PW-1:0] d_den  [N+1];
  logic [PW-1:0] d_rr   [N+1];
  logic [PW-1:0] d_rn   [N+1];
  logic [W-1:0]  d_rq   [N+1];
  logic          d_rb   [N+1];
  logic [PW-1:0] d_ir   [N+1];
  logic [PW-1:0] d_in   [N+1];
  logic [W-1:0]  d_iq   [N+1];
  logic          d_ib   [N+1];

  assign s_axis_tready = en;
  assign d_rr[0] = '0;
  assign d_ir[0] = '0;

  cau_front #(
    .WORD_BITS(WORD_BITS),
    .FRAC_BITS(FRAC_BITS)
  ) u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .valid_i  (s_axis_tvalid),
    .action_i (cau_action_e'(s_axis_tuser)),
    .a_re_i   (s_axis_tdata[W-1:0]),
    .a_im_i   (s_axis_tdata[DATA_W+W-1:DATA_W]),
    .b_re_i   (s_axis_tdata[2*DATA_W+W-1:2*DATA_W]),
    .b_im_i   (s_axis_tdata[3*DATA_W+W-1:3*DATA_W]),
    .valid_o  (d_v[0]),
    .tag_o    (d_tag[0]),
    .re_q_o   (d_rq[0]),
    .re_big_o (d_rb[0]),
    .im_q_o   (d_iq[0]),
    .im_big_o (d_ib[0]),
    .re_num_o (d_rn[0]),
    .im_num_o (d_in[0]),
    .den_o    (d_den[0])
  );

  // one quotient bit per stage
  for (genvar k = 0; k < N; k++) begin : g_div
    cau_div_stage #(
      .WORD_BITS(WORD_BITS)
    ) u_stage (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .en_i     (en),
      .valid_i  (d_v[k]),
      .tag_i    (d_tag[k]),
      .den_i    (d_den[k]),
      .re_r_i   (d_rr[k]),
      .re_num_i (d_rn[k]),
      .re_q_i   (d_rq[k]),
      .re_big_i (d_rb[k]),
      .im_r_i   (d_ir[k]),
      .im_num_i (d_in[k]),
      .im_q_i   (d_iq[k]),
      .im_big_i (d_ib[k]),
      .valid_o  (d_v[k+1]),
      .tag_o    (d_tag[k+1]),
      .den_o    (d_den[k+1]),
      .re_r_o   (d_rr[k+1]),
      .re_num_o (d_rn[k+1]),
      .re_q_o   (d_rq[k+1]),
      .re_big_o (d_rb[k+1]),
      .im_r_o   (d_ir[k+1]),
      .im_num_o (d_in[k+1]),
      .im_q_o   (d_iq[k+1]),
      .im_big_o (d_ib[k+1])
    );
  end

  cau_back #(
    .WORD_BITS(WORD_BITS)
  ) u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (d_v[N]),
    .tag_i    (d_tag[N]),
    .re_q_i   (d_rq[N]),
    .re_big_i (d_rb[N]),
    .im_q_i   (d_iq[N]),
    .im_big_i (d_ib[N]),
    .en_o     (en),
    .ready_i  (m_axis_tready),
    .valid_o  (m_axis_tvalid),
    .res_re_o (m_axis_tdata[DATA_W-1:0]),
    .res_im_o (m_axis_tdata[2*DATA_W-1:DATA_W]),
    .ov_o     (m_axis_tuser[0]),
    .dz_o     (m_axis_tuser[1])
  );

  // input side only stalls while a result is held at the output
  a_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid)
    else $error("input stalled with empty output register");

  // zero divisor gives zero result and no overflow
  a_dz_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser[1]) |-> (m_axis_tdata == '0 && !m_axis_tuser[0]))
    else $error("divide by zero result not cleared");

  // stalled input with full output stays stalled until a result drains
  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!s_axis_tready && !m_axis_tready) |=> !s_axis_tready)
    else $error("skid register released without output transaction");

endmodule

FILE: rtl/cau_front.sv
// Front end: operand capture, magnitudes, products, sums and scaling.
// Five register stages; uses cau_pkg.
`timescale 1ns / 1ps

module cau_front import cau_pkg::*; #(
  parameter int unsigned WORD_BITS = WORD_BITS_DEF,
  parameter int unsigned FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   en_i,
  input  logic                   valid_i,
  input  cau_action_e            action_i,
  input  logic [WORD_BITS-1:0]   a_re_i,
  input  logic [WORD_BITS-1:0]   a_im_i,
  input  logic [WORD_BITS-1:0]   b_re_i,
  input  logic [WORD_BITS-1:0]   b_im_i,
  output logic                   valid_o,
  output cau_tag_t               tag_o,
  output logic [WORD_BITS-1:0]   re_q_o,
  output logic                   re_big_o,
  output logic [WORD_BITS-1:0]   im_q_o,
  output logic                   im_big_o,
  output logic [2*WORD_BITS-1:0] re_num_o,
  output logic [2*WORD_BITS-1:0] im_num_o,
  output logic [2*WORD_BITS-1:0] den_o
);

  localparam int unsigned W  = WORD_BITS;
  localparam int unsigned PW = 2 * WORD_BITS;
  localparam int unsigned SW = PW + 2;

  function automatic logic [W-1:0] mag_of(logic [W-1:0] x);
    mag_of = x[W-1] ? (~x + 1'b1) : x;
  endfunction

  function automatic logic [SW-1:0] to_s(logic [PW-1:0] m, logic n);
    to_s = n ? (SW'(0) - SW'(m)) : SW'(m);
  endfunction

  // Stage 1: operand capture
  logic        v1_q;
  cau_action_e act1_q;
  logic [W-1:0] ar1_q, ai1_q, br1_q, bi1_q;

  // Stage 2: magnitudes, signs, add/sub
  logic        v2_q;
  cau_action_e act2_q;
  logic [W-1:0] ma2_q, mb2_q, mc2_q, md2_q;
  logic         sa2_q, sb2_q, sc2_q, sd2_q;
  logic [W:0]   as_re2_q, as_im2_q;
  logic [W:0]   as_re2_d, as_im2_d;

  // Stage 3: products
  logic        v3_q;
  cau_action_e act3_q;
  logic [PW-1:0] ac3_q, bd3_q, bc3_q, ad3_q, cc3_q, dd3_q;
  logic          sac3_q, sbd3_q, sbc3_q, sad3_q;
  logic [W:0]    as_re3_q, as_im3_q;

  // Stage 4: signed sums and denominator
  logic        v4_q;
  cau_action_e act4_q;
  logic [SW-1:0] re4_q, im4_q, re4_d, im4_d;
  logic [PW-1:0] den4_q;
  logic [SW-1:0] ac_s, bd_s, bc_s, ad_s;

  // Stage 5: magnitude and scaling
  logic [SW-1:0] re_abs, im_abs;
  logic [PW-1:0] re_val, im_val;
  logic          is_div, is_mul;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q    <= 1'b0;
      v2_q    <= 1'b0;
      v3_q    <= 1'b0;
      v4_q    <= 1'b0;
      valid_o <= 1'b0;
    end else if (en_i) begin
      v1_q    <= valid_i;
      v2_q    <= v1_q;
      v3_q    <= v2_q;
      v4_q    <= v3_q;
      valid_o <= v4_q;
    end
  end

  // add/sub in one extra bit, never overflows
  always_comb begin
    if (act1_q == ACT_SUB) begin
      as_re2_d = {ar1_q[W-1], ar1_q} - {br1_q[W-1], br1_q};
      as_im2_d = {ai1_q[W-1], ai1_q} - {bi1_q[W-1], bi1_q};
    end else begin
      as_re2_d = {ar1_q[W-1], ar1_q} + {br1_q[W-1], br1_q};
      as_im2_d = {ai1_q[W-1], ai1_q} + {bi1_q[W-1], bi1_q};
    end
  end

  // signed partial terms
  assign ac_s = to_s(ac3_q, sac3_q);
  assign bd_s = to_s(bd3_q, sbd3_q);
  assign bc_s = to_s(bc3_q, sbc3_q);
  assign ad_s = to_s(ad3_q, sad3_q);

  always_comb begin
    case (act3_q)
      ACT_MUL: begin
        re4_d = ac_s - bd_s;
        im4_d = bc_s + ad_s;
      end
      ACT_DIV: begin
        re4_d = ac_s + bd_s;
        im4_d = bc_s - ad_s;
      end
      default: begin
        re4_d = SW'(signed'(as_re3_q));
        im4_d = SW'(signed'(as_im3_q));
      end
    endcase
  end

  // back to sign and magnitude; products drop FRAC_BITS toward zero
  assign is_div = (act4_q == ACT_DIV);
  assign is_mul = (act4_q == ACT_MUL);
  assign re_abs = re4_q[SW-1] ? (SW'(0) - re4_q) : re4_q;
  assign im_abs = im4_q[SW-1] ? (SW'(0) - im4_q) : im4_q;
  assign re_val = is_mul ? (re_abs[PW-1:0] >> FRAC_BITS) : re_abs[PW-1:0];
  assign im_val = is_mul ? (im_abs[PW-1:0] >> FRAC_BITS) : im_abs[PW-1:0];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      act1_q <= action_i;
      ar1_q  <= a_re_i;
      ai1_q  <= a_im_i;
      br1_q  <= b_re_i;
      bi1_q  <= b_im_i;

      act2_q   <= act1_q;
      ma2_q    <= mag_of(ar1_q);
      mb2_q    <= mag_of(ai1_q);
      mc2_q    <= mag_of(br1_q);
      md2_q    <= mag_of(bi1_q);
      sa2_q    <= ar1_q[W-1];
      sb2_q    <= ai1_q[W-1];
      sc2_q    <= br1_q[W-1];
      sd2_q    <= bi1_q[W-1];
      as_re2_q <= as_re2_d;
      as_im2_q <= as_im2_d;

      act3_q   <= act2_q;
      ac3_q    <= PW'(ma2_q) * PW'(mc2_q);
      bd3_q    <= PW'(mb2_q) * PW'(md2_q);
      bc3_q    <= PW'(mb2_q) * PW'(mc2_q);
      ad3_q    <= PW'(ma2_q) * PW'(md2_q);
      cc3_q    <= PW'(mc2_q) * PW'(mc2_q);
      dd3_q    <= PW'(md2_q) * PW'(md2_q);
      sac3_q   <= sa2_q ^ sc2_q;
      sbd3_q   <= sb2_q ^ sd2_q;
      sbc3_q   <= sb2_q ^ sc2_q;
      sad3_q   <= sa2_q ^ sd2_q;
      as_re3_q <= as_re2_q;
      as_im3_q <= as_im2_q;

      act4_q <= act3_q;
      re4_q  <= re4_d;
      im4_q  <= im4_d;
      den4_q <= cc3_q + dd3_q;

      tag_o.is_div <= is_div;
      tag_o.dz     <= is_div && (den4_q == '0);
      tag_o.re_neg <= re4_q[SW-1];
      tag_o.im_neg <= im4_q[SW-1];
      re_q_o       <= is_div ? '0 : re_val[W-1:0];
      im_q_o       <= is_div ? '0 : im_val[W-1:0];
      re_big_o     <= !is_div && (re_val[PW-1:W] != '0);
      im_big_o     <= !is_div && (im_val[PW-1:W] != '0);
      re_num_o     <= re_abs[PW-1:0];
      im_num_o     <= im_abs[PW-1:0];
      den_o        <= den4_q;
    end
  end

endmodule

FILE: rtl/cau_div_stage.sv
// One restoring-division step for both result parts, registered.
// Items other than divide pass their result unchanged; uses cau_pkg.
`timescale 1ns / 1ps

module cau_div_stage import cau_pkg::*; #(
  parameter int unsigned WORD_BITS = WORD_BITS_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   en_i,
  input  logic                   valid_i,
  input  cau_tag_t               tag_i,
  input  logic [2*WORD_BITS-1:0] den_i,
  input  logic [2*WORD_BITS-1:0] re_r_i,
  input  logic [2*WORD_BITS-1:0] re_num_i,
  input  logic [WORD_BITS-1:0]   re_q_i,
  input  logic                   re_big_i,
  input  logic [2*WORD_BITS-1:0] im_r_i,
  input  logic [2*WORD_BITS-1:0] im_num_i,
  input  logic [WORD_BITS-1:0]   im_q_i,
  input  logic                   im_big_i,
  output logic                   valid_o,
  output cau_tag_t               tag_o,
  output logic [2*WORD_BITS-1:0] den_o,
  output logic [2*WORD_BITS-1:0] re_r_o,
  output logic [2*WORD_BITS-1:0] re_num_o,
  output logic [WORD_BITS-1:0]   re_q_o,
  output logic                   re_big_o,
  output logic [2*WORD_BITS-1:0] im_r_o,
  output logic [2*WORD_BITS-1:0] im_num_o,
  output logic [WORD_BITS-1:0]   im_q_o,
  output logic                   im_big_o
);

  localparam int unsigned W  = WORD_BITS;
  localparam int unsigned PW = 2 * WORD_BITS;
  localparam int unsigned LW = 2 * PW + W + 1;

  // {remainder, numerator, quotient, big}; a quotient bit shifted out
  // past the word sticks in big
  function automatic logic [LW-1:0] step(logic [PW-1:0] r, logic [PW-1:0] num,
                                         logic [W-1:0] q, logic big,
                                         logic [PW-1:0] den);
    logic [PW-1:0] r2;
    logic          qb;
    r2 = {r[PW-2:0], num[PW-1]};
    qb = (r2 >= den);
    if (qb) r2 = r2 - den;
    step = {r2, num[PW-2:0], 1'b0, q[W-2:0], qb, big | q[W-1]};
  endfunction

  logic [LW-1:0] re_nx, im_nx;

  assign re_nx = step(re_r_i, re_num_i, re_q_i, re_big_i, den_i);
  assign im_nx = step(im_r_i, im_num_i, im_q_i, im_big_i, den_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else if (en_i) begin
      valid_o <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      tag_o    <= tag_i;
      den_o    <= den_i;
      re_r_o   <= re_nx[LW-1 -: PW];
      re_num_o <= re_nx[LW-PW-1 -: PW];
      im_r_o   <= im_nx[LW-1 -: PW];
      im_num_o <= im_nx[LW-PW-1 -: PW];
      if (tag_i.is_div) begin
        re_q_o   <= re_nx[W:1];
        re_big_o <= re_nx[0];
        im_q_o   <= im_nx[W:1];
        im_big_o <= im_nx[0];
      end else begin
        re_q_o   <= re_q_i;
        re_big_o <= re_big_i;
        im_q_o   <= im_q_i;
        im_big_o <= im_big_i;
      end
    end
  end

endmodule

FILE: rtl/cau_back.sv
// Back end: saturation, flags, output register and skid register.
// Drives the pipeline enable; uses cau_pkg.
`timescale 1ns / 1ps

module cau_back import cau_pkg::*; #(
  parameter int unsigned WORD_BITS = WORD_BITS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 valid_i,
  input  cau_tag_t             tag_i,
  input  logic [WORD_BITS-1:0] re_q_i,
  input  logic                 re_big_i,
  input  logic [WORD_BITS-1:0] im_q_i,
  input  logic                 im_big_i,
  output logic                 en_o,
  input  logic                 ready_i,
  output logic                 valid_o,
  output logic [DATA_W-1:0]    res_re_o,
  output logic [DATA_W-1:0]    res_im_o,
  output logic                 ov_o,
  output logic                 dz_o
);

  localparam int unsigned W = WORD_BITS;
  localparam logic [W-1:0] LIM = {1'b1, {(W-1){1'b0}}};

  // {overflow, value}
  function automatic logic [W:0] sat(logic [W-1:0] q, logic big, logic neg);
    if (neg) begin
      if (big || (q > LIM)) sat = {1'b1, LIM};
      else                  sat = {1'b0, ~q + 1'b1};
    end else begin
      if (big || q[W-1]) sat = {1'b1, ~LIM};
      else               sat = {1'b0, q};
    end
  endfunction

  logic [W:0]        re_s, im_s;
  logic [DATA_W-1:0] p_re, p_im;
  logic              p_ov;

  assign re_s = tag_i.dz ? '0 : sat(re_q_i, re_big_i, tag_i.re_neg);
  assign im_s = tag_i.dz ? '0 : sat(im_q_i, im_big_i, tag_i.im_neg);
  assign p_re = DATA_W'(signed'(re_s[W-1:0]));
  assign p_im = DATA_W'(signed'(im_s[W-1:0]));
  assign p_ov = re_s[W] | im_s[W];

  // output register plus skid register
  logic              skid_v_q;
  logic [DATA_W-1:0] skid_re_q, skid_im_q;
  logic              skid_ov_q, skid_dz_q;
  logic              take;

  assign en_o = !skid_v_q;
  assign take = valid_o && ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o  <= 1'b0;
      skid_v_q <= 1'b0;
    end else if (skid_v_q) begin
      if (take) skid_v_q <= 1'b0;
    end else if (valid_i) begin
      if (valid_o && !take) skid_v_q <= 1'b1;
      else                  valid_o  <= 1'b1;
    end else if (take) begin
      valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_v_q) begin
      if (take) begin
        res_re_o <= skid_re_q;
        res_im_o <= skid_im_q;
        ov_o     <= skid_ov_q;
        dz_o     <= skid_dz_q;
      end
    end else if (valid_i) begin
      if (valid_o && !take) begin
        skid_re_q <= p_re;
        skid_im_q <= p_im;
        skid_ov_q <= p_ov;
        skid_dz_q <= tag_i.dz;
      end else begin
        res_re_o <= p_re;
        res_im_o <= p_im;
        ov_o     <= p_ov;
        dz_o     <= tag_i.dz;
      end
    end
  end

endmodule
